### rtl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal writer package
// Shared types and fixed codes for the text terminal writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

    // request kinds as seen on the slave tuser field
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_WRITE,
        OP_CLEAR,
        OP_READ,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
    } t_cmd;

    // slave tdata layout, lowest field last
    typedef struct packed {
        logic [7:0] pos_row;
        logic [7:0] pos_col;
        logic [7:0] char_code;
    } t_in_data;

    // master tdata layout, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic        ignored;
        logic        scrolled;
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
    } t_result;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

### rtl/text_terminal_writer.sv
// ----------------------------------------------------------------------------
// Text terminal writer
// Text-mode screen engine: cell store, cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
//  port group  dir  bits        contents (lowest bit first)
//  s_axis      in   tdata 24    char_code, pos_col, pos_row
//                   tuser 2     kind
//  m_axis      out  tdata 32    cursor_row, cursor_col, cell_data, scrolled,
//                               ignored, two zero bits
//  cfg         in   data 8      text_attribute
//
//  Cursor moves, writes and reads: one registered result per request;
//  the back end executes one command at a time from a two-deep queue.
//  Scroll: a copy pass plus bottom row blanking.
//  Clear screen: a sweep over all COLUMNS*ROWS cells, one cell write per cycle.
//  After reset the store is swept to blanks with s_axis_tready low;
//  configuration writes are always taken.
//  A stalled result sits in the output register while further requests queue.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // char_code, pos_col, pos_row
    input  wire logic [1:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // cursor_row, cursor_col, cell_data,
                                             // scrolled, ignored
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    ttw_pkg::t_in_data s_data;
    ttw_pkg::t_cmd     push_data, pop_data;
    ttw_pkg::t_result  m_data;
    logic              q_push, q_full, q_pop, q_empty, init_busy;

    assign s_data        = s_axis_tdata;
    assign m_axis_tdata  = m_data;
    assign o_cfg_ready   = 1'b1;

    ttw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_data),
        .i_s_kind    (s_axis_tuser),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_q_push    (q_push),
        .o_q_data    (push_data)
    );

    ttw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (pop_data),
        .o_empty (q_empty)
    );

    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_data    (pop_data),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_data)
    );

endmodule

`default_nettype wire

### rtl/ttw_front.sv
// ----------------------------------------------------------------------------
// Text terminal writer front end
// Takes requests, checks positions and decodes control characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire ttw_pkg::t_in_data i_s_data,
    input  wire logic [1:0]        i_s_kind,
    input  wire logic              i_q_full,
    input  wire logic              i_init_busy,
    output logic                   o_q_push,
    output ttw_pkg::t_cmd          o_q_data
);

    logic in_range;

    assign in_range = ({1'b0, i_s_data.pos_col} < 9'(COLUMNS)) &&
                      ({1'b0, i_s_data.pos_row} < 9'(ROWS));

    assign o_s_ready = !i_q_full && !i_init_busy;
    assign o_q_push  = i_s_valid && o_s_ready;

    always_comb begin
        o_q_data.ch  = i_s_data.char_code;
        o_q_data.col = i_s_data.pos_col;
        o_q_data.row = i_s_data.pos_row;
        unique case (i_s_kind)
            ttw_pkg::KIND_PUT: begin
                priority if (i_s_data.char_code == ttw_pkg::CH_NEWLINE)
                    o_q_data.op = ttw_pkg::OP_NEWLINE;
                else if (i_s_data.char_code == ttw_pkg::CH_RETURN)
                    o_q_data.op = ttw_pkg::OP_RETURN;
                else if (i_s_data.char_code == ttw_pkg::CH_BACKSPACE)
                    o_q_data.op = ttw_pkg::OP_BACKSPACE;
                else
                    o_q_data.op = ttw_pkg::OP_PUT;
            end
            ttw_pkg::KIND_WRITE:
                o_q_data.op = in_range ? ttw_pkg::OP_WRITE : ttw_pkg::OP_IGNORE;
            ttw_pkg::KIND_CLEAR:
                o_q_data.op = ttw_pkg::OP_CLEAR;
            ttw_pkg::KIND_READ:
                o_q_data.op = in_range ? ttw_pkg::OP_READ : ttw_pkg::OP_IGNORE;
            default:
                o_q_data.op = ttw_pkg::OP_IGNORE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ttw_queue.sv
// ----------------------------------------------------------------------------
// Text terminal writer command queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ttw_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output ttw_pkg::t_cmd      o_data,
    output logic               o_empty
);

    ttw_pkg::t_cmd           r_buf [ttw_pkg::Q_DEPTH];
    logic [ttw_pkg::Q_AW:0]  r_wr_ptr, n_wr_ptr;
    logic [ttw_pkg::Q_AW:0]  r_rd_ptr, n_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[ttw_pkg::Q_AW] != r_rd_ptr[ttw_pkg::Q_AW]) &&
                     (r_wr_ptr[ttw_pkg::Q_AW-1:0] == r_rd_ptr[ttw_pkg::Q_AW-1:0]);
    assign o_data  = r_buf[r_rd_ptr[ttw_pkg::Q_AW-1:0]];

    assign n_wr_ptr = r_wr_ptr + (ttw_pkg::Q_AW+1)'(i_push && !o_full);
    assign n_rd_ptr = r_rd_ptr + (ttw_pkg::Q_AW+1)'(i_pop && !o_empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wr_ptr[ttw_pkg::Q_AW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/ttw_back.sv
// ----------------------------------------------------------------------------
// Text terminal writer back end
// Cell store, cursor, scroll and clear sweeps, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_q_empty,
    input  wire ttw_pkg::t_cmd i_q_data,
    output logic               o_q_pop,
    output logic               o_init_busy,
    output logic               o_m_valid,
    input  wire logic          i_m_ready,
    output ttw_pkg::t_result   o_m_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
    localparam logic [7:0]    LASTC  = 8'(COLUMNS - 1);
    localparam logic [7:0]    LASTR  = 8'(ROWS - 1);

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rd_data;

    ttw_pkg::t_state  r_state, n_state;
    ttw_pkg::t_cmd    r_cmd, n_cmd;
    ttw_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_attr, n_attr;
    logic [7:0]       r_row, n_row;
    logic [7:0]       r_col, n_col;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_wr_addr, n_wr_addr;
    logic             r_pend, n_pend;
    logic             r_src_done, n_src_done;
    logic             r_scrolled, n_scrolled;

    logic             w_en, rd_en, load_out, exec_scroll, idx_last;
    logic [AW-1:0]    w_addr, rd_addr, t_addr;
    logic [15:0]      w_data, blank;
    logic [7:0]       t_row, t_col;

    assign blank    = {r_attr, ttw_pkg::CH_BLANK};
    assign idx_last = (r_idx == LAST);
    assign t_addr   = AW'(t_row) * COLS_A + AW'(t_col);

    // a wrap or newline on the bottom row pushes the screen up
    assign exec_scroll = (r_row == LASTR) &&
                         (((r_cmd.op == ttw_pkg::OP_PUT) && (r_col == LASTC)) ||
                          (r_cmd.op == ttw_pkg::OP_NEWLINE));

    assign load_out = (r_state == ttw_pkg::ST_FINISH) && (!r_out_valid || i_m_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttw_pkg::ST_INIT:   if (idx_last) n_state = ttw_pkg::ST_IDLE;
            ttw_pkg::ST_IDLE:   if (!i_q_empty) n_state = ttw_pkg::ST_EXEC;
            ttw_pkg::ST_EXEC: begin
                priority if (r_cmd.op == ttw_pkg::OP_CLEAR)
                    n_state = ttw_pkg::ST_CLEAR;
                else if (exec_scroll)
                    n_state = ttw_pkg::ST_SCROLL;
                else
                    n_state = ttw_pkg::ST_FINISH;
            end
            ttw_pkg::ST_SCROLL: if (r_src_done) n_state = ttw_pkg::ST_BLANK;
            ttw_pkg::ST_BLANK:  if (idx_last) n_state = ttw_pkg::ST_FINISH;
            ttw_pkg::ST_CLEAR:  if (idx_last) n_state = ttw_pkg::ST_FINISH;
            ttw_pkg::ST_FINISH: if (load_out) n_state = ttw_pkg::ST_IDLE;
            default:            n_state = ttw_pkg::ST_INIT;
        endcase
    end

    // datapath and store control
    always_comb begin
        w_en       = 1'b0;
        rd_en      = 1'b0;
        t_row      = r_row;
        t_col      = r_col;
        w_addr     = t_addr;
        rd_addr    = t_addr;
        w_data     = blank;
        o_q_pop    = 1'b0;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_idx      = r_idx;
        n_wr_addr  = r_wr_addr;
        n_pend     = r_pend;
        n_src_done = r_src_done;
        n_scrolled = r_scrolled;
        n_attr     = i_cfg_valid ? i_cfg_data : r_attr;

        unique case (r_state)
            ttw_pkg::ST_INIT: begin
                w_en   = 1'b1;
                w_addr = r_idx;
                w_data = {ttw_pkg::RESET_ATTR, ttw_pkg::CH_BLANK};
                n_idx  = r_idx + AW'(1);
            end
            ttw_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop    = 1'b1;
                    n_cmd      = i_q_data;
                    n_scrolled = 1'b0;
                end
            end
            ttw_pkg::ST_EXEC: begin
                n_idx      = COLS_A;
                n_pend     = 1'b0;
                n_src_done = 1'b0;
                unique case (r_cmd.op)
                    ttw_pkg::OP_PUT: begin
                        w_en   = 1'b1;
                        w_data = {r_attr, r_cmd.ch};
                        if (r_col == LASTC) begin
                            n_col = '0;
                            if (r_row != LASTR) n_row = r_row + 8'd1;
                        end else begin
                            n_col = r_col + 8'd1;
                        end
                    end
                    ttw_pkg::OP_NEWLINE: begin
                        n_col = '0;
                        if (r_row != LASTR) n_row = r_row + 8'd1;
                    end
                    ttw_pkg::OP_RETURN: n_col = '0;
                    ttw_pkg::OP_BACKSPACE: begin
                        priority if (r_col != '0) begin
                            t_col = r_col - 8'd1;
                            n_col = t_col;
                            w_en  = 1'b1;
                        end else if (r_row != '0) begin
                            t_row = r_row - 8'd1;
                            t_col = LASTC;
                            n_row = t_row;
                            n_col = LASTC;
                            w_en  = 1'b1;
                        end else begin
                            // top-left corner: cursor stays, nothing blanked
                        end
                    end
                    ttw_pkg::OP_WRITE: begin
                        t_row  = r_cmd.row;
                        t_col  = r_cmd.col;
                        w_en   = 1'b1;
                        w_data = {r_attr, r_cmd.ch};
                    end
                    ttw_pkg::OP_CLEAR: begin
                        n_idx = '0;
                        n_row = '0;
                        n_col = '0;
                    end
                    ttw_pkg::OP_READ: begin
                        t_row = r_cmd.row;
                        t_col = r_cmd.col;
                        rd_en = 1'b1;
                    end
                    default: ;
                endcase
            end
            ttw_pkg::ST_SCROLL: begin
                // read row n+1 while the previous read lands one row up
                w_en   = r_pend;
                w_addr = r_wr_addr;
                w_data = r_rd_data;
                n_pend = !r_src_done;
                if (!r_src_done) begin
                    rd_en      = 1'b1;
                    rd_addr    = r_idx;
                    n_wr_addr  = r_idx - COLS_A;
                    n_idx      = idx_last ? BOTTOM : r_idx + AW'(1);
                    n_src_done = idx_last;
                end
            end
            ttw_pkg::ST_BLANK: begin
                w_en   = 1'b1;
                w_addr = r_idx;
                n_idx  = r_idx + AW'(1);
                if (idx_last) begin
                    n_row      = LASTR;
                    n_col      = '0;
                    n_scrolled = 1'b1;
                end
            end
            ttw_pkg::ST_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_idx;
                n_idx  = r_idx + AW'(1);
            end
            ttw_pkg::ST_FINISH: ;
            default: ;
        endcase
    end

    always_comb begin
        n_out            = r_out;
        n_out_valid      = r_out_valid && !i_m_ready;
        if (load_out) begin
            n_out_valid      = 1'b1;
            n_out.pad        = '0;
            n_out.ignored    = (r_cmd.op == ttw_pkg::OP_IGNORE);
            n_out.scrolled   = r_scrolled;
            n_out.cell_data  = (r_cmd.op == ttw_pkg::OP_READ) ? r_rd_data : '0;
            n_out.cursor_col = r_col[6:0];
            n_out.cursor_row = r_row[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttw_pkg::ST_INIT;
            r_out_valid <= 1'b0;
            r_attr      <= ttw_pkg::RESET_ATTR;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_src_done  <= 1'b0;
            r_scrolled  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_attr      <= n_attr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_src_done  <= n_src_done;
            r_scrolled  <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_out     <= n_out;
        r_wr_addr <= n_wr_addr;
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_init_busy = (r_state == ttw_pkg::ST_INIT);
    assign o_m_valid   = r_out_valid;
    assign o_m_data    = r_out;

endmodule

`default_nettype wire

### rtl/ttw_checker.sv
// ----------------------------------------------------------------------------
// Text terminal writer checker
// Port-level checks on results and reset behaviour, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    ttw_pkg::t_result res;

    assign res = m_axis_tdata;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // clearing pass keeps requests out straight after reset
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("request or result during clearing pass");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.cursor_col < COLUMNS) && (res.cursor_row < ROWS)
                          && (res.pad == 2'b00))
        else $error("cursor out of screen");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.ignored |-> !res.scrolled && (res.cell_data == 16'h0000))
        else $error("ignored request carries data or scroll");

    a_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.scrolled |->
            (res.cursor_row == 5'(ROWS - 1)) && (res.cursor_col == 7'd0))
        else $error("scroll left cursor off bottom row start");

endmodule

bind text_terminal_writer ttw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ttw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb_text_terminal_writer.sv
// ----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives put-char, positioned write, clear and cell read requests at the
// stream input with bursty timing, stalls the result stream, and checks each
// result against a cycle-free screen/cursor predictor. A short directed table
// covers the edges; random phases follow, each under its own text attribute.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_terminal_writer;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int PHASE_REQUESTS = 300;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int DIRECTED_ROWS  = 22;

    // result-side stall patterns
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;
    localparam int READY_PERIOD = 3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        typed;
        logic [4:0]  e_row;
        logic [6:0]  e_col;
        logic [15:0] e_data;
        logic        e_scrolled;
        logic        e_ignored;
    } t_probe;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = ttw_pkg::KIND_PUT;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;

    // predicted screen state
    logic [15:0] screen_image [CELLS];
    int          cursor_r;
    int          cursor_c;
    logic [7:0]  text_attr;

    ttw_pkg::t_result awaited_reports [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          ready_mode = READY_ALWAYS;
    int          window_left = 0;
    t_probe      directed_table [DIRECTED_ROWS];

    text_terminal_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cursor-driven character output; returns 1 when the screen scrolled
    function automatic bit put_glyph(input logic [7:0] ch);
        logic [15:0] blank;
        blank = {text_attr, ttw_pkg::CH_BLANK};
        case (ch)
            ttw_pkg::CH_NEWLINE: begin
                cursor_r++;
                cursor_c = 0;
            end
            ttw_pkg::CH_RETURN: cursor_c = 0;
            ttw_pkg::CH_BACKSPACE: begin
                if (cursor_c > 0) begin
                    cursor_c--;
                    screen_image[cursor_r * COLUMNS + cursor_c] = blank;
                end else if (cursor_r > 0) begin
                    cursor_r--;
                    cursor_c = COLUMNS - 1;
                    screen_image[cursor_r * COLUMNS + cursor_c] = blank;
                end
            end
            default: begin
                screen_image[cursor_r * COLUMNS + cursor_c] = {text_attr, ch};
                cursor_c++;
                if (cursor_c >= COLUMNS) begin
                    cursor_c = 0;
                    cursor_r++;
                end
            end
        endcase
        if (cursor_r >= ROWS) begin
            for (int i = COLUMNS; i < CELLS; i++)
                screen_image[i - COLUMNS] = screen_image[i];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_image[i] = blank;
            cursor_r = ROWS - 1;
            cursor_c = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic ttw_pkg::t_result emulate_terminal(
        input logic [1:0] kind, input logic [7:0] ch,
        input logic [7:0] col, input logic [7:0] row);
        ttw_pkg::t_result rep;
        bit               on_screen;
        rep = '0;
        on_screen = (col < COLUMNS) && (row < ROWS);
        case (kind)
            ttw_pkg::KIND_PUT: rep.scrolled = put_glyph(ch);
            ttw_pkg::KIND_WRITE: begin
                if (on_screen) screen_image[row * COLUMNS + col] = {text_attr, ch};
                else rep.ignored = 1'b1;
            end
            ttw_pkg::KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_image[i] = {text_attr, ttw_pkg::CH_BLANK};
                cursor_r = 0;
                cursor_c = 0;
            end
            default: begin
                if (on_screen) rep.cell_data = screen_image[row * COLUMNS + col];
                else rep.ignored = 1'b1;
            end
        endcase
        rep.cursor_row = cursor_r[4:0];
        rep.cursor_col = cursor_c[6:0];
        return rep;
    endfunction

    // one request on the stream input; valid stays up across a burst
    task automatic send_request(input logic [1:0] kind, input logic [7:0] ch,
                                input logic [7:0] col, input logic [7:0] row,
                                input bit typed, input ttw_pkg::t_result typed_rep);
        int               gap;
        ttw_pkg::t_result rep;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col, ch};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        rep = emulate_terminal(kind, ch, col, row);
        awaited_reports.push_back(typed ? typed_rep : rep);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_all_reports();
        while (awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        text_attr = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed text with some positioned traffic and rare clears
    task automatic send_random_request();
        logic [1:0] kind;
        logic [7:0] ch, col, row;
        int         pick;
        pick = $urandom_range(0, 99);
        kind = pick < 60 ? ttw_pkg::KIND_PUT : pick < 77 ? ttw_pkg::KIND_WRITE :
               pick < 99 ? ttw_pkg::KIND_READ : ttw_pkg::KIND_CLEAR;
        ch  = 8'($urandom_range(0, 255));
        col = 8'($urandom_range(0, 255));
        row = 8'($urandom_range(0, 255));
        if (kind == ttw_pkg::KIND_PUT) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      ch = 8'($urandom_range(32, 126));
            else if (pick < 86) ch = ttw_pkg::CH_NEWLINE;
            else if (pick < 90) ch = ttw_pkg::CH_RETURN;
            else if (pick < 97) ch = ttw_pkg::CH_BACKSPACE;
        end else if ((kind == ttw_pkg::KIND_WRITE || kind == ttw_pkg::KIND_READ) &&
                     $urandom_range(0, 99) < 85) begin
            col = 8'($urandom_range(0, COLUMNS - 1));
            row = 8'($urandom_range(0, ROWS - 1));
        end
        send_request(kind, ch, col, row, 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        if (window_left == 0) begin
            ready_mode  = $urandom_range(READY_ALWAYS, READY_PERIOD);
            window_left = $urandom_range(16, 300);
        end
        window_left--;
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:      m_axis_tready <= (window_left % 16) >= 5;
        endcase
    end

    always @(posedge i_clk) begin : check_reports
        ttw_pkg::t_result got;
        ttw_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = ttw_pkg::t_result'(m_axis_tdata);
            if (awaited_reports.size() == 0) begin
                $error("result with nothing outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = awaited_reports.pop_front();
                if (got.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                    error_count++;
                end
                if (got.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
                    error_count++;
                end
                if (got.cell_data !== want.cell_data) begin
                    $error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
                    error_count++;
                end
                if (got.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                    error_count++;
                end
                if (got.ignored !== want.ignored) begin
                    $error("ignored: expected %0d, got %0d", want.ignored, got.ignored);
                    error_count++;
                end
            end
        end
    end

    // counts cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_text_terminal_writer: FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0]       phase_attr [PHASES];
        ttw_pkg::t_result typed_rep;

        for (int i = 0; i < CELLS; i++)
            screen_image[i] = {ttw_pkg::RESET_ATTR, ttw_pkg::CH_BLANK};
        cursor_r  = 0;
        cursor_c  = 0;
        text_attr = ttw_pkg::RESET_ATTR;

        // kind, ch, col, row, typed, then the expected result where typed
        directed_table = '{
            '{ttw_pkg::KIND_READ, 8'h00, 8'd0, 8'd0, 1'b1, '0, '0, 16'h0720, '0, '0},
            '{ttw_pkg::KIND_READ, 8'hFF, 8'd79, 8'd24, 1'b1, '0, '0, 16'h0720, '0, '0},
            '{ttw_pkg::KIND_READ, 8'h00, 8'd80, 8'd0, 1'b1, '0, '0, '0, '0, 1'b1},
            '{ttw_pkg::KIND_READ, 8'hFF, 8'd255, 8'd255, 1'b1, '0, '0, '0, '0, 1'b1},
            '{ttw_pkg::KIND_WRITE, 8'h41, 8'd0, 8'd25, 1'b1, '0, '0, '0, '0, 1'b1},
            '{ttw_pkg::KIND_WRITE, 8'h41, 8'd255, 8'd24, 1'b1, '0, '0, '0, '0, 1'b1},
            '{ttw_pkg::KIND_PUT, ttw_pkg::CH_BACKSPACE, 8'd0, 8'd0, 1'b1, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, 8'h41, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, 8'h00, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_WRITE, ttw_pkg::CH_NEWLINE, 8'd79, 8'd24, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_READ, 8'h00, 8'd79, 8'd24, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, ttw_pkg::CH_BACKSPACE, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, ttw_pkg::CH_NEWLINE, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, 8'h7A, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, ttw_pkg::CH_RETURN, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, ttw_pkg::CH_BACKSPACE, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_READ, 8'h00, 8'd79, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_PUT, 8'h80, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_READ, 8'h00, 8'd1, 8'd0, 1'b0, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_CLEAR, 8'hFF, 8'd255, 8'd255, 1'b1, '0, '0, '0, '0, '0},
            '{ttw_pkg::KIND_READ, 8'h00, 8'd40, 8'd12, 1'b1, '0, '0, 16'h0720, '0, '0}
        };

        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        phase_attr[2] = 8'($urandom_range(0, 255));
        phase_attr[3] = 8'($urandom_range(0, 255));
        phase_attr[4] = 8'($urandom_range(0, 255));
        phase_attr[5] = 8'h80;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the first request waits out the store sweep after reset
        foreach (directed_table[i]) begin
            typed_rep            = '0;
            typed_rep.cursor_row = directed_table[i].e_row;
            typed_rep.cursor_col = directed_table[i].e_col;
            typed_rep.cell_data  = directed_table[i].e_data;
            typed_rep.scrolled   = directed_table[i].e_scrolled;
            typed_rep.ignored    = directed_table[i].e_ignored;
            send_request(directed_table[i].kind, directed_table[i].ch, directed_table[i].col,
                         directed_table[i].row, directed_table[i].typed, typed_rep);
        end
        end_burst();

        for (int p = 0; p < PHASES; p++) begin
            wait_all_reports();
            write_attribute(phase_attr[p]);
            repeat (PHASE_REQUESTS) send_random_request();
            end_burst();
        end

        wait_all_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_text_terminal_writer: PASS");
        else
            $display("tb_text_terminal_writer: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
